>>> rtl/core/packet_header_checker_assert.svh
// assertion macros shared by the packet header checker modules
// expects clk and arst_n in the scope of the including module
`ifndef PACKET_HEADER_CHECKER_ASSERT_SVH
`define PACKET_HEADER_CHECKER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PHC_ASSERT_IMP(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("phc: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define PHC_ASSERT_NXT(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("phc: next-cycle check failed");

`endif

>>> rtl/core/phc_pkg.sv
// types, constants and the crc step for the packet header checker
// no dependencies
`timescale 1ns / 1ps

package phc_pkg;

	localparam int HEADER_BYTES = 14;
	localparam int CRC_FIELD_AT = 12;
	localparam int POS_W = $clog2(HEADER_BYTES);
	localparam int QUEUE_DEPTH = 2;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SHORT       = 3'd1,
		ST_BAD_MAGIC   = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_TOO_LONG    = 3'd4,
		ST_CRC_MISMATCH = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CFG_MAGIC   = 2'd0,
		CFG_MAJOR   = 2'd1,
		CFG_MINOR   = 2'd2,
		CFG_P_LIMIT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [15:0] magic_word;
		logic [7:0]  major_version;
		logic [7:0]  minor_version;
		logic [7:0]  message_type;
		logic [7:0]  flag_bits;
		logic [7:0]  source_node;
		logic [7:0]  dest_node;
		logic [15:0] sequence_number;
		logic [15:0] payload_length;
		logic [15:0] received_crc;
	} header_t;

	// one queued transaction for the back end
	typedef struct packed {
		logic        is_short;
		header_t     hdr;
		logic [15:0] calc_crc;
	} rec_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] magic_word;
		logic [7:0]  major_version;
		logic [7:0]  minor_version;
		logic [7:0]  message_type;
		logic [7:0]  flag_bits;
		logic [7:0]  source_node;
		logic [7:0]  dest_node;
		logic [15:0] sequence_number;
		logic [15:0] payload_length;
		logic [15:0] received_crc;
	} out_item_t;

	// crc-16/ccitt-false, one byte, msb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/core/phc_front.sv
// front end: byte capture, position count and running crc
// depends on phc_pkg and packet_header_checker_assert.svh
`timescale 1ns / 1ps
`include "packet_header_checker_assert.svh"

module phc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  phc_pkg::in_item_t in_item,
	input  logic              queue_full,
	output logic              push,
	output phc_pkg::rec_t     push_rec
);

	localparam int STORE = phc_pkg::HEADER_BYTES - 1;

	logic [phc_pkg::POS_W-1:0] pos_q;
	logic [15:0]               crc_q;
	logic                      skip_q;
	logic [7:0]                hdr_q [STORE];

	logic        in_fire;
	logic        last_byte;
	logic [7:0]  crc_in;
	logic [15:0] crc_next;

	assign in_ready  = !queue_full;
	assign in_fire   = in_valid && in_ready;
	assign last_byte = (pos_q == phc_pkg::POS_W'(phc_pkg::HEADER_BYTES - 1));

	always_comb begin
		crc_in   = (pos_q >= phc_pkg::POS_W'(phc_pkg::CRC_FIELD_AT)) ? 8'h00 : in_item.data_byte;
		crc_next = phc_pkg::crc16_byte(crc_q, crc_in);
		push     = in_fire && !skip_q && (last_byte || in_item.end_of_buffer);
		push_rec = '0;
		if (last_byte) begin
			push_rec.is_short            = 1'b0;
			push_rec.hdr.magic_word      = {hdr_q[1], hdr_q[0]};
			push_rec.hdr.major_version   = hdr_q[2];
			push_rec.hdr.minor_version   = hdr_q[3];
			push_rec.hdr.message_type    = hdr_q[4];
			push_rec.hdr.flag_bits       = hdr_q[5];
			push_rec.hdr.source_node     = hdr_q[6];
			push_rec.hdr.dest_node       = hdr_q[7];
			push_rec.hdr.sequence_number = {hdr_q[9], hdr_q[8]};
			push_rec.hdr.payload_length  = {hdr_q[11], hdr_q[10]};
			push_rec.hdr.received_crc    = {in_item.data_byte, hdr_q[12]};
			push_rec.calc_crc            = crc_next;
		end else begin
			push_rec.is_short = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !skip_q && !last_byte) begin
			hdr_q[pos_q] <= in_item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= phc_pkg::CRC_INIT;
			skip_q <= 1'b0;
		end else if (in_fire) begin
			if (skip_q) begin
				if (in_item.end_of_buffer) begin
					skip_q <= 1'b0;
				end
			end else if (last_byte || in_item.end_of_buffer) begin
				pos_q  <= '0;
				crc_q  <= phc_pkg::CRC_INIT;
				skip_q <= last_byte && !in_item.end_of_buffer;
			end else begin
				pos_q <= pos_q + 1'b1;
				crc_q <= crc_next;
			end
		end
	end

	// skipping trailing bytes only ever happens from a restarted packet
	`PHC_ASSERT_IMP(a_skip_restarted, skip_q, (pos_q == '0) && (crc_q == phc_pkg::CRC_INIT))
	`PHC_ASSERT_IMP(a_pos_bound, 1'b1, pos_q <= phc_pkg::POS_W'(phc_pkg::HEADER_BYTES - 1))

endmodule

>>> rtl/core/phc_queue.sv
// short transaction queue between front and back ends, registered head
// depends on phc_pkg and packet_header_checker_assert.svh
`timescale 1ns / 1ps
`include "packet_header_checker_assert.svh"

module phc_queue #(
	parameter int DEPTH = phc_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  phc_pkg::rec_t push_rec,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output phc_pkg::rec_t head_rec
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	phc_pkg::rec_t mem [DEPTH];

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             head_valid_q;
	phc_pkg::rec_t    head_q;
	logic             load;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign load       = (cnt_q != '0) && (!head_valid_q || pop);
	assign head_valid = head_valid_q;
	assign head_rec   = head_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_rec;
		end
		if (load) begin
			head_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			cnt_q        <= '0;
			head_valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (load) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(load);
			if (load) begin
				head_valid_q <= 1'b1;
			end else if (pop) begin
				head_valid_q <= 1'b0;
			end
		end
	end

	`PHC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`PHC_ASSERT_NXT(a_head_refill, !head_valid_q && (cnt_q != '0), head_valid_q)

endmodule

>>> rtl/core/phc_back.sv
// back end: configuration registers, header checks and result register
// depends on phc_pkg
`timescale 1ns / 1ps

module phc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               head_valid,
	input  phc_pkg::rec_t      head_rec,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output phc_pkg::out_item_t out_item
);

	logic [15:0] magic_q;
	logic [7:0]  major_q;
	logic [7:0]  minor_q;
	logic [15:0] p_limit_q;

	logic               out_valid_q;
	phc_pkg::out_item_t out_q;
	phc_pkg::status_t   status;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		if (head_rec.is_short) begin
			status = phc_pkg::ST_SHORT;
		end else if (head_rec.hdr.magic_word != magic_q) begin
			status = phc_pkg::ST_BAD_MAGIC;
		end else if (head_rec.hdr.major_version != major_q ||
				head_rec.hdr.minor_version > minor_q) begin
			status = phc_pkg::ST_BAD_VERSION;
		end else if (head_rec.hdr.payload_length > p_limit_q) begin
			status = phc_pkg::ST_TOO_LONG;
		end else if (head_rec.calc_crc != head_rec.hdr.received_crc) begin
			status = phc_pkg::ST_CRC_MISMATCH;
		end else begin
			status = phc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= '0;
			major_q   <= '0;
			minor_q   <= '0;
			p_limit_q <= 16'hFFFF;
		end else if (cfg_write_en) begin
			case (phc_pkg::cfg_reg_t'(cfg_index))
				phc_pkg::CFG_MAGIC: begin
					magic_q <= cfg_data;
				end
				phc_pkg::CFG_MAJOR: begin
					major_q <= cfg_data[7:0];
				end
				phc_pkg::CFG_MINOR: begin
					minor_q <= cfg_data[7:0];
				end
				phc_pkg::CFG_P_LIMIT: begin
					p_limit_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.status          <= status;
			out_q.magic_word      <= head_rec.hdr.magic_word;
			out_q.major_version   <= head_rec.hdr.major_version;
			out_q.minor_version   <= head_rec.hdr.minor_version;
			out_q.message_type    <= head_rec.hdr.message_type;
			out_q.flag_bits       <= head_rec.hdr.flag_bits;
			out_q.source_node     <= head_rec.hdr.source_node;
			out_q.dest_node       <= head_rec.hdr.dest_node;
			out_q.sequence_number <= head_rec.hdr.sequence_number;
			out_q.payload_length  <= head_rec.hdr.payload_length;
			out_q.received_crc    <= head_rec.hdr.received_crc;
		end
	end

endmodule

>>> rtl/core/packet_header_checker.sv
// packet header checker top level: front end, transaction queue, back end
// depends on phc_pkg, phc_front, phc_queue, phc_back
// one byte accepted per cycle; in_ready drops only while the queue is full
// a header's result goes via queue memory, the queue head and the result register
// arst_n clears position, crc, skip flag, queue and output valid, registers to defaults
// no clearing pass after reset, bytes accepted from the first cycle
`timescale 1ns / 1ps

module packet_header_checker #(
	parameter int QUEUE_DEPTH = phc_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  phc_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output phc_pkg::out_item_t out_item,
	input  logic               cfg_write_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic          queue_full;
	logic          push;
	phc_pkg::rec_t push_rec;
	logic          pop;
	logic          head_valid;
	phc_pkg::rec_t head_rec;

	phc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.queue_full (queue_full),
		.push       (push),
		.push_rec   (push_rec)
	);

	phc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	phc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head_valid   (head_valid),
		.head_rec     (head_rec),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_item     (out_item)
	);

endmodule

>>> bench/tb_packet_header_checker.sv
// self-checking bench for packet_header_checker: directed packet table, then random packets
// depends on phc_pkg and packet_header_checker; results checked against an internal header predictor
`timescale 1ns / 1ps

module tb_packet_header_checker;

	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_GAP = 40;
	localparam int SEGMENTS = 6;
	localparam int SEGMENT_BYTES = 225;
	localparam int DIR_ROWS = 14;

	typedef enum logic [1:0] {
		CRC_RAW,
		CRC_GOOD,
		CRC_BAD
	} crc_fill_t;

	typedef struct {
		bit                 cfg_en;
		phc_pkg::cfg_reg_t  cfg_idx;
		logic [15:0]        cfg_val;
		phc_pkg::header_t   hdr;
		int                 nbytes;
		int                 trail;
		crc_fill_t          crc_fill;
		bit                 check_status;
		phc_pkg::status_t   want;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	phc_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready = 1'b0;
	phc_pkg::out_item_t out_item;
	logic               cfg_write_en;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	// predictor state and register copies
	logic [15:0] magic_cfg;
	logic [7:0]  major_cfg;
	logic [7:0]  minor_cfg;
	logic [15:0] plen_cfg;
	logic [3:0]  hdr_pos;
	logic [15:0] hdr_crc;
	logic [7:0]  hdr_store [phc_pkg::HEADER_BYTES];
	bit          skip_rest;

	phc_pkg::out_item_t pending_headers [$];
	dir_row_t  dir_rows [DIR_ROWS];
	int        send_idle_pct = 34;
	int        recv_idle_pct = 56;
	int        bytes_sent = 0;
	int        quiet_cycles = 0;
	bit        failed = 0;

	packet_header_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ phc_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void restart_header();
		hdr_pos = '0;
		hdr_crc = phc_pkg::CRC_INIT;
		skip_rest = 1'b0;
	endfunction

	function automatic bit predict_header_byte(input phc_pkg::in_item_t it,
			output phc_pkg::out_item_t res);
		logic [15:0] magic;
		logic [15:0] plen;
		logic [15:0] rcrc;
		res = '0;
		if (skip_rest) begin
			if (it.end_of_buffer) begin
				restart_header();
			end
			return 1'b0;
		end
		if (hdr_pos >= phc_pkg::HEADER_BYTES) begin
			hdr_pos = '0;
		end
		hdr_store[hdr_pos] = it.data_byte;
		hdr_crc = crc_step(hdr_crc,
			(hdr_pos >= phc_pkg::CRC_FIELD_AT) ? 8'h00 : it.data_byte);
		hdr_pos = hdr_pos + 4'd1;
		if (hdr_pos == phc_pkg::HEADER_BYTES) begin
			magic = {hdr_store[1], hdr_store[0]};
			plen = {hdr_store[11], hdr_store[10]};
			rcrc = {hdr_store[13], hdr_store[12]};
			res.magic_word = magic;
			res.major_version = hdr_store[2];
			res.minor_version = hdr_store[3];
			res.message_type = hdr_store[4];
			res.flag_bits = hdr_store[5];
			res.source_node = hdr_store[6];
			res.dest_node = hdr_store[7];
			res.sequence_number = {hdr_store[9], hdr_store[8]};
			res.payload_length = plen;
			res.received_crc = rcrc;
			if (magic != magic_cfg) begin
				res.status = phc_pkg::ST_BAD_MAGIC;
			end else if (hdr_store[2] != major_cfg || hdr_store[3] > minor_cfg) begin
				res.status = phc_pkg::ST_BAD_VERSION;
			end else if (plen > plen_cfg) begin
				res.status = phc_pkg::ST_TOO_LONG;
			end else if (hdr_crc != rcrc) begin
				res.status = phc_pkg::ST_CRC_MISMATCH;
			end else begin
				res.status = phc_pkg::ST_OK;
			end
			if (it.end_of_buffer) begin
				restart_header();
			end else begin
				skip_rest = 1'b1;
			end
			return 1'b1;
		end
		if (it.end_of_buffer) begin
			res.status = phc_pkg::ST_SHORT;
			restart_header();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic dir_row_t mk_row(input bit cfg_en, input phc_pkg::cfg_reg_t idx,
			input logic [15:0] val, input logic [15:0] magic, input logic [7:0] major,
			input logic [7:0] minor, input logic [7:0] fill, input logic [15:0] plen,
			input int nbytes, input int trail, input crc_fill_t crc_fill, input bit check,
			input phc_pkg::status_t want);
		dir_row_t row;
		row.cfg_en = cfg_en;
		row.cfg_idx = idx;
		row.cfg_val = val;
		row.hdr.magic_word = magic;
		row.hdr.major_version = major;
		row.hdr.minor_version = minor;
		row.hdr.message_type = fill;
		row.hdr.flag_bits = fill;
		row.hdr.source_node = fill;
		row.hdr.dest_node = fill;
		row.hdr.sequence_number = {fill, fill};
		row.hdr.payload_length = plen;
		row.hdr.received_crc = {fill, fill};
		row.nbytes = nbytes;
		row.trail = trail;
		row.crc_fill = crc_fill;
		row.check_status = check;
		row.want = want;
		return row;
	endfunction

	function automatic logic [15:0] pick_value(input logic [15:0] top);
		case ($urandom_range(0, 3))
			0: begin
				return 16'h0000;
			end
			1: begin
				return top;
			end
			default: begin
				return 16'($urandom) & top;
			end
		endcase
	endfunction

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic send_byte(input phc_pkg::in_item_t it, input bit check_status,
			input phc_pkg::status_t want);
		phc_pkg::out_item_t res;
		int                 gap;
		gap = 0;
		while (gap < MAX_GAP && chance(send_idle_pct)) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		bytes_sent++;
		if (predict_header_byte(it, res)) begin
			if (check_status) begin
				res.status = want;
			end
			pending_headers.push_back(res);
		end
	endtask

	task automatic send_packet(input phc_pkg::header_t h, input int nbytes, input int trail,
			input crc_fill_t crc_fill, input bit check_status, input phc_pkg::status_t want);
		logic [7:0]        b [phc_pkg::HEADER_BYTES];
		logic [15:0]       c;
		phc_pkg::in_item_t it;
		b[0] = h.magic_word[7:0];
		b[1] = h.magic_word[15:8];
		b[2] = h.major_version;
		b[3] = h.minor_version;
		b[4] = h.message_type;
		b[5] = h.flag_bits;
		b[6] = h.source_node;
		b[7] = h.dest_node;
		b[8] = h.sequence_number[7:0];
		b[9] = h.sequence_number[15:8];
		b[10] = h.payload_length[7:0];
		b[11] = h.payload_length[15:8];
		b[12] = h.received_crc[7:0];
		b[13] = h.received_crc[15:8];
		if (crc_fill != CRC_RAW) begin
			c = phc_pkg::CRC_INIT;
			for (int i = 0; i < phc_pkg::HEADER_BYTES; i++) begin
				c = crc_step(c, (i < phc_pkg::CRC_FIELD_AT) ? b[i] : 8'h00);
			end
			if (crc_fill == CRC_BAD) begin
				c = c ^ 16'h0001;
			end
			b[12] = c[7:0];
			b[13] = c[15:8];
		end
		for (int i = 0; i < nbytes; i++) begin
			it.data_byte = b[i];
			it.end_of_buffer = (i == nbytes - 1) && (trail == 0);
			send_byte(it, check_status, want);
		end
		// bytes after the header up to the end flag
		for (int i = 0; i < trail; i++) begin
			it.data_byte = 8'($urandom);
			it.end_of_buffer = (i == trail - 1);
			send_byte(it, check_status, want);
		end
	endtask

	task automatic random_packet();
		phc_pkg::header_t h;
		crc_fill_t        crc_fill;
		int               nbytes;
		int               trail;
		h.magic_word = chance(85) ? magic_cfg : 16'($urandom);
		h.major_version = chance(85) ? major_cfg : 8'($urandom);
		h.minor_version = chance(85) ? 8'($urandom_range(0, minor_cfg)) : 8'($urandom);
		h.message_type = 8'($urandom);
		h.flag_bits = 8'($urandom);
		h.source_node = 8'($urandom);
		h.dest_node = 8'($urandom);
		h.sequence_number = 16'($urandom);
		h.payload_length = chance(85) ? 16'($urandom_range(0, plen_cfg)) : 16'($urandom);
		h.received_crc = 16'($urandom);
		crc_fill = chance(85) ? CRC_GOOD : CRC_RAW;
		if (chance(10)) begin
			nbytes = $urandom_range(1, phc_pkg::HEADER_BYTES - 1);
			trail = 0;
		end else begin
			nbytes = phc_pkg::HEADER_BYTES;
			trail = chance(40) ? 0 : $urandom_range(1, 6);
		end
		send_packet(h, nbytes, trail, crc_fill, 1'b0, phc_pkg::ST_OK);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_headers.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input phc_pkg::cfg_reg_t idx, input logic [15:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			phc_pkg::CFG_MAGIC: begin
				magic_cfg = val;
			end
			phc_pkg::CFG_MAJOR: begin
				major_cfg = val[7:0];
			end
			phc_pkg::CFG_MINOR: begin
				minor_cfg = val[7:0];
			end
			phc_pkg::CFG_P_LIMIT: begin
				plen_cfg = val;
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		out_ready <= arst_n && !chance(recv_idle_pct);
	end

	always @(posedge clk) begin
		phc_pkg::out_item_t exp_hdr;
		if (arst_n && out_valid && out_ready) begin
			if (pending_headers.size() == 0) begin
				$error("result transaction with no header pending");
				failed = 1'b1;
			end else begin
				exp_hdr = pending_headers.pop_front();
				check_field("status", 16'(exp_hdr.status), 16'(out_item.status));
				check_field("magic_word", exp_hdr.magic_word, out_item.magic_word);
				check_field("major_version", 16'(exp_hdr.major_version),
					16'(out_item.major_version));
				check_field("minor_version", 16'(exp_hdr.minor_version),
					16'(out_item.minor_version));
				check_field("message_type", 16'(exp_hdr.message_type),
					16'(out_item.message_type));
				check_field("flag_bits", 16'(exp_hdr.flag_bits), 16'(out_item.flag_bits));
				check_field("source_node", 16'(exp_hdr.source_node),
					16'(out_item.source_node));
				check_field("dest_node", 16'(exp_hdr.dest_node), 16'(out_item.dest_node));
				check_field("sequence_number", exp_hdr.sequence_number,
					out_item.sequence_number);
				check_field("payload_length", exp_hdr.payload_length,
					out_item.payload_length);
				check_field("received_crc", exp_hdr.received_crc, out_item.received_crc);
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int seg_start;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_write_en <= 1'b0;
		cfg_index <= phc_pkg::CFG_MAGIC;
		cfg_data <= '0;
		magic_cfg = 16'h0000;
		major_cfg = 8'h00;
		minor_cfg = 8'h00;
		plen_cfg = 16'hFFFF;
		foreach (hdr_store[i]) begin
			hdr_store[i] = 8'h00;
		end
		restart_header();

		// rows up to the first register write run on the reset defaults
		dir_rows[0] = mk_row(1'b0, phc_pkg::CFG_MAGIC, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF,
			8'hFF, 16'hFFFF, 1, 0, CRC_RAW, 1'b1, phc_pkg::ST_SHORT);
		dir_rows[1] = mk_row(1'b0, phc_pkg::CFG_MAGIC, 16'h0000, 16'h0000, 8'h00, 8'h00,
			8'h00, 16'h0000, phc_pkg::HEADER_BYTES, 0, CRC_GOOD, 1'b1, phc_pkg::ST_OK);
		dir_rows[2] = mk_row(1'b0, phc_pkg::CFG_MAGIC, 16'h0000, 16'hFFFF, 8'h00, 8'h00,
			8'h00, 16'h0000, phc_pkg::HEADER_BYTES, 1, CRC_GOOD, 1'b1,
			phc_pkg::ST_BAD_MAGIC);
		dir_rows[3] = mk_row(1'b0, phc_pkg::CFG_MAGIC, 16'h0000, 16'h0000, 8'h01, 8'h00,
			8'h00, 16'h0000, phc_pkg::HEADER_BYTES, 3, CRC_GOOD, 1'b1,
			phc_pkg::ST_BAD_VERSION);
		dir_rows[4] = mk_row(1'b0, phc_pkg::CFG_MAGIC, 16'h0000, 16'h0000, 8'h00, 8'h01,
			8'h00, 16'h0000, phc_pkg::HEADER_BYTES, 0, CRC_GOOD, 1'b1,
			phc_pkg::ST_BAD_VERSION);
		dir_rows[5] = mk_row(1'b0, phc_pkg::CFG_MAGIC, 16'h0000, 16'h0000, 8'h00, 8'h00,
			8'h00, 16'hFFFF, phc_pkg::HEADER_BYTES, 0, CRC_GOOD, 1'b1, phc_pkg::ST_OK);
		dir_rows[6] = mk_row(1'b1, phc_pkg::CFG_P_LIMIT, 16'h0000, 16'h0000, 8'h00, 8'h00,
			8'h00, 16'h0001, phc_pkg::HEADER_BYTES, 0, CRC_GOOD, 1'b1,
			phc_pkg::ST_TOO_LONG);
		dir_rows[7] = mk_row(1'b0, phc_pkg::CFG_MAGIC, 16'h0000, 16'h0000, 8'h00, 8'h00,
			8'h00, 16'h0000, phc_pkg::HEADER_BYTES, 0, CRC_BAD, 1'b1,
			phc_pkg::ST_CRC_MISMATCH);
		dir_rows[8] = mk_row(1'b1, phc_pkg::CFG_MAGIC, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00,
			8'hFF, 16'h0000, phc_pkg::HEADER_BYTES, 0, CRC_GOOD, 1'b1, phc_pkg::ST_OK);
		dir_rows[9] = mk_row(1'b1, phc_pkg::CFG_MAJOR, 16'h00FF, 16'hFFFF, 8'hFF, 8'h00,
			8'h00, 16'h0000, phc_pkg::HEADER_BYTES, 0, CRC_GOOD, 1'b1, phc_pkg::ST_OK);
		dir_rows[10] = mk_row(1'b1, phc_pkg::CFG_MINOR, 16'h00FF, 16'hFFFF, 8'hFF, 8'hFF,
			8'h00, 16'h0000, phc_pkg::HEADER_BYTES, 2, CRC_GOOD, 1'b1, phc_pkg::ST_OK);
		dir_rows[11] = mk_row(1'b1, phc_pkg::CFG_P_LIMIT, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF,
			8'hA5, 16'hFFFF, phc_pkg::HEADER_BYTES, 0, CRC_GOOD, 1'b1,
			phc_pkg::ST_BAD_MAGIC);
		dir_rows[12] = mk_row(1'b0, phc_pkg::CFG_MAGIC, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF,
			8'h5A, 16'h0000, phc_pkg::HEADER_BYTES - 1, 0, CRC_RAW, 1'b1,
			phc_pkg::ST_SHORT);
		dir_rows[13] = mk_row(1'b0, phc_pkg::CFG_MAGIC, 16'h0000, 16'hFFFF, 8'hFF, 8'h80,
			8'h5A, 16'h1234, phc_pkg::HEADER_BYTES, 5, CRC_RAW, 1'b0, phc_pkg::ST_OK);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].cfg_en) begin
				settle();
				write_reg(dir_rows[r].cfg_idx, dir_rows[r].cfg_val);
			end
			send_packet(dir_rows[r].hdr, dir_rows[r].nbytes, dir_rows[r].trail,
				dir_rows[r].crc_fill, dir_rows[r].check_status, dir_rows[r].want);
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			settle();
			case (seg / 2)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 56;
				end
				1: begin
					send_idle_pct = 56;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_reg(phc_pkg::CFG_MAGIC, pick_value(16'hFFFF));
			write_reg(phc_pkg::CFG_MAJOR, pick_value(16'h00FF));
			write_reg(phc_pkg::CFG_MINOR, pick_value(16'h00FF));
			write_reg(phc_pkg::CFG_P_LIMIT, pick_value(16'hFFFF));
			seg_start = bytes_sent;
			while (bytes_sent - seg_start < SEGMENT_BYTES) begin
				random_packet();
			end
		end

		settle();
		if (!failed) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> packet_header_checker.f
+incdir+rtl/core
rtl/core/phc_pkg.sv
rtl/core/phc_front.sv
rtl/core/phc_queue.sv
rtl/core/phc_back.sv
rtl/core/packet_header_checker.sv
bench/tb_packet_header_checker.sv
